// ===== sv/sbrs_pkg.sv =====
package sbrs_pkg;

   // tracker ids, also the csr index of each tracker's smoothing weight
   localparam int NUM_TRK = 6;
   localparam logic [2:0] TRK_OVERALL = 3'd0;
   localparam logic [2:0] TRK_BASS    = 3'd1;
   localparam logic [2:0] TRK_MID     = 3'd2;
   localparam logic [2:0] TRK_TREBLE  = 3'd3;
   localparam logic [2:0] TRK_LOW     = 3'd4;
   localparam logic [2:0] TRK_HIGH    = 3'd5;

   localparam logic [2:0] REG_WINDOW_LENGTH = 3'd6;

   localparam logic [7:0] SMOOTH_RESET = 8'd25;
   localparam logic [6:0] WINDOW_RESET = 7'd70;

   // bass positions 0-1, mid 2-3
   localparam logic [3:0] BASS_END = 4'd2;
   localparam logic [3:0] MID_END  = 4'd4;

   // rounding term of the divide by 255
   localparam logic [7:0] ROUND = 8'd127;
   localparam logic [7:0] DIVISOR = 8'd255;

   // last step of an 8-digit serial pass
   localparam logic [2:0] DIGIT_LAST = 3'd7;

   typedef struct packed {
      logic        start;
      logic [2:0]  trk;
      logic [15:0] value;
   } sq_cmd_type;

   typedef struct packed {
      logic        busy;
      logic        done;
      logic [2:0]  trk;
      logic [7:0]  root;
   } sq_stat_type;

endpackage

// ===== sv/sound_band_running_stats_core.sv =====
// channel | ports                                   | direction
// req     | req_valid req_stall req_level           | in  (one level word)
//         | req_band_position                       |
// rsp     | rsp_valid rsp_stall rsp_*_average       | out (twelve stats word)
//         | rsp_*_deviation                         |
// csr     | csr_write csr_index csr_data            | in  (write only)
//
// One level at a time. Each tracker update runs in a shared digit-serial
// unit: load, 8 steps forming delta squared and delta times weight, 8 steps
// forming the variance sum, then the divide-by-255 pipe. A level updates 2
// trackers, 4 when it closes a window; rsp_valid rises once the last root is
// done and ST_OUT has loaded the result register.
// Reset is synchronous; the result register lets the next level in while
// a word waits under rsp_stall.
module sound_band_running_stats_core (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_level,
   input  logic [3:0] req_band_position,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_overall_average,
   output logic [7:0] rsp_overall_deviation,
   output logic [7:0] rsp_bass_average,
   output logic [7:0] rsp_bass_deviation,
   output logic [7:0] rsp_mid_average,
   output logic [7:0] rsp_mid_deviation,
   output logic [7:0] rsp_treble_average,
   output logic [7:0] rsp_treble_deviation,
   output logic [7:0] rsp_low_peak_average,
   output logic [7:0] rsp_low_peak_deviation,
   output logic [7:0] rsp_high_peak_average,
   output logic [7:0] rsp_high_peak_deviation,
   input  logic       csr_write,
   input  logic [2:0] csr_index,
   input  logic [7:0] csr_data
);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_LOAD = 3'd1;
   localparam logic [2:0] ST_MUL1 = 3'd2;
   localparam logic [2:0] ST_MUL2 = 3'd3;
   localparam logic [2:0] ST_DIV  = 3'd4;
   localparam logic [2:0] ST_WAIT = 3'd5;
   localparam logic [2:0] ST_OUT  = 3'd6;

   localparam logic [1:0] JOB_BAND    = 2'd0;
   localparam logic [1:0] JOB_OVERALL = 2'd1;
   localparam logic [1:0] JOB_LOW     = 2'd2;
   localparam logic [1:0] JOB_HIGH    = 2'd3;

   // divide pipe timing inside ST_DIV
   localparam logic [2:0] DIV_STEP_IN  = 3'd0;
   localparam logic [2:0] DIV_STEP_OUT = 3'd2;
   localparam logic [2:0] DIV_VAR_OUT  = 3'd3;

   logic [2:0]  state_ff, state_in;
   logic [1:0]  job_ff, job_in;
   logic [2:0]  cnt_ff, cnt_in;

   logic [7:0]  smooth_ff [sbrs_pkg::NUM_TRK];
   logic [7:0]  smooth_in [sbrs_pkg::NUM_TRK];
   logic [6:0]  win_len_ff, win_len_in;
   logic [7:0]  mean_ff [sbrs_pkg::NUM_TRK];
   logic [7:0]  mean_in [sbrs_pkg::NUM_TRK];
   logic [15:0] var_ff [sbrs_pkg::NUM_TRK];
   logic [15:0] var_in [sbrs_pkg::NUM_TRK];
   logic [7:0]  dev_ff [sbrs_pkg::NUM_TRK];
   logic [7:0]  dev_in [sbrs_pkg::NUM_TRK];
   logic [7:0]  win_low_ff, win_low_in;
   logic [7:0]  win_high_ff, win_high_in;
   logic [6:0]  win_cnt_ff, win_cnt_in;

   logic [7:0]  level_ff, level_in;
   logic [2:0]  band_trk_ff, band_trk_in;
   logic [7:0]  low_pk_ff, low_pk_in;
   logic [7:0]  high_pk_ff, high_pk_in;
   logic        fire_ff, fire_in;

   logic [2:0]  trk_ff, trk_in;
   logic        neg_ff, neg_in;
   logic [7:0]  mag_sr_ff, mag_sr_in;
   logic [7:0]  s_sr_ff, s_sr_in;
   logic [15:0] md_ff, md_in;
   logic [15:0] sq_acc_ff, sq_acc_in;
   logic [15:0] prod_acc_ff, prod_acc_in;
   logic [23:0] dd_sh_ff, dd_sh_in;
   logic [23:0] vs_sh_ff, vs_sh_in;
   logic [23:0] num_acc_ff, num_acc_in;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [7:0]  out_avg_ff [sbrs_pkg::NUM_TRK];
   logic [7:0]  out_avg_in [sbrs_pkg::NUM_TRK];
   logic [7:0]  out_dev_ff [sbrs_pkg::NUM_TRK];
   logic [7:0]  out_dev_in [sbrs_pkg::NUM_TRK];

   logic        req_accept;
   logic [6:0]  cnt_next;
   logic [7:0]  lo_next;
   logic [7:0]  hi_next;
   logic        close_win;
   logic [2:0]  job_trk;
   logic [7:0]  job_val;
   logic [1:0]  last_job;
   logic [8:0]  delta;
   logic [7:0]  mag;
   logic [23:0] step_num;
   logic [23:0] div_x;
   logic [15:0] div_q;
   logic [7:0]  step8;

   sbrs_pkg::sq_cmd_type  sq_cmd;
   sbrs_pkg::sq_stat_type sq_stat;

   sbrs_div255 u_div (
      .clock (clock),
      .in_x  (div_x),
      .out_q (div_q)
   );

   sbrs_sqrt u_sqrt (
      .clock (clock),
      .reset (reset),
      .cmd   (sq_cmd),
      .stat  (sq_stat)
   );

   assign req_stall = (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;

   always_comb begin
      case (job_ff)
         JOB_BAND: begin
            job_trk = band_trk_ff;
            job_val = level_ff;
         end
         JOB_OVERALL: begin
            job_trk = sbrs_pkg::TRK_OVERALL;
            job_val = level_ff;
         end
         JOB_LOW: begin
            job_trk = sbrs_pkg::TRK_LOW;
            job_val = low_pk_ff;
         end
         default: begin
            job_trk = sbrs_pkg::TRK_HIGH;
            job_val = high_pk_ff;
         end
      endcase
      last_job = fire_ff ? JOB_HIGH : JOB_OVERALL;

      cnt_next = win_cnt_ff + 7'd1;
      lo_next = (req_level < win_low_ff) ? req_level : win_low_ff;
      hi_next = (req_level > win_high_ff) ? req_level : win_high_ff;
      close_win = (cnt_next >= win_len_ff);

      delta = {1'b0, job_val} - {1'b0, mean_ff[job_trk]};
      mag = delta[8] ? (~delta[7:0] + 8'd1) : delta[7:0];

      // step: work on the magnitude, add the rounding term on a rise, take it off on a fall, negate after
      if (neg_ff) begin
         if (prod_acc_ff > {8'b0, sbrs_pkg::ROUND}) begin
            step_num = {8'b0, prod_acc_ff - {8'b0, sbrs_pkg::ROUND}};
         end else begin
            step_num = 24'd0;
         end
      end else begin
         step_num = {8'b0, prod_acc_ff + {8'b0, sbrs_pkg::ROUND}};
      end
      div_x = (cnt_ff == DIV_STEP_IN) ? step_num : num_acc_ff;
      step8 = neg_ff ? (8'd0 - div_q[7:0]) : div_q[7:0];
   end

   always_comb begin
      state_in = state_ff;
      job_in = job_ff;
      cnt_in = cnt_ff;
      smooth_in = smooth_ff;
      win_len_in = win_len_ff;
      mean_in = mean_ff;
      var_in = var_ff;
      dev_in = dev_ff;
      win_low_in = win_low_ff;
      win_high_in = win_high_ff;
      win_cnt_in = win_cnt_ff;
      level_in = level_ff;
      band_trk_in = band_trk_ff;
      low_pk_in = low_pk_ff;
      high_pk_in = high_pk_ff;
      fire_in = fire_ff;
      trk_in = trk_ff;
      neg_in = neg_ff;
      mag_sr_in = mag_sr_ff;
      s_sr_in = s_sr_ff;
      md_in = md_ff;
      sq_acc_in = sq_acc_ff;
      prod_acc_in = prod_acc_ff;
      dd_sh_in = dd_sh_ff;
      vs_sh_in = vs_sh_ff;
      num_acc_in = num_acc_ff;
      out_avg_in = out_avg_ff;
      out_dev_in = out_dev_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      sq_cmd.start = 1'b0;
      sq_cmd.trk = trk_ff;
      sq_cmd.value = div_q;

      if (csr_write) begin
         if (csr_index < sbrs_pkg::REG_WINDOW_LENGTH) begin
            smooth_in[csr_index] = csr_data;
         end else if (csr_index == sbrs_pkg::REG_WINDOW_LENGTH) begin
            win_len_in = csr_data[6:0];
         end
      end

      if (sq_stat.done) begin
         dev_in[sq_stat.trk] = sq_stat.root;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               level_in = req_level;
               if (req_band_position < sbrs_pkg::BASS_END) begin
                  band_trk_in = sbrs_pkg::TRK_BASS;
               end else if (req_band_position < sbrs_pkg::MID_END) begin
                  band_trk_in = sbrs_pkg::TRK_MID;
               end else begin
                  band_trk_in = sbrs_pkg::TRK_TREBLE;
               end
               low_pk_in = lo_next;
               high_pk_in = hi_next;
               fire_in = close_win;
               if (close_win) begin
                  win_low_in = 8'hFF;
                  win_high_in = 8'h00;
                  win_cnt_in = 7'd0;
               end else begin
                  win_low_in = lo_next;
                  win_high_in = hi_next;
                  win_cnt_in = cnt_next;
               end
               job_in = JOB_BAND;
               state_in = ST_LOAD;
            end
         end
         ST_LOAD: begin
            trk_in = job_trk;
            neg_in = delta[8];
            mag_sr_in = mag;
            s_sr_in = smooth_ff[job_trk];
            md_in = {8'b0, mag};
            sq_acc_in = 16'd0;
            prod_acc_in = 16'd0;
            vs_sh_in = {8'b0, var_ff[job_trk]};
            cnt_in = 3'd0;
            state_in = ST_MUL1;
         end
         ST_MUL1: begin
            // |delta|^2 and |delta|*weight, one multiplier bit per cycle
            sq_acc_in = sq_acc_ff + (mag_sr_ff[0] ? md_ff : 16'd0);
            prod_acc_in = prod_acc_ff + (s_sr_ff[0] ? md_ff : 16'd0);
            md_in = {md_ff[14:0], 1'b0};
            mag_sr_in = {1'b0, mag_sr_ff[7:1]};
            s_sr_in = {1'b0, s_sr_ff[7:1]};
            cnt_in = cnt_ff + 3'd1;
            if (cnt_ff == sbrs_pkg::DIGIT_LAST) begin
               dd_sh_in = {8'b0, sq_acc_in};
               s_sr_in = smooth_ff[trk_ff];
               num_acc_in = {16'b0, sbrs_pkg::ROUND};
               cnt_in = 3'd0;
               state_in = ST_MUL2;
            end
         end
         ST_MUL2: begin
            // weight bit set adds delta^2, clear adds var: (255-s) is ~s
            num_acc_in = num_acc_ff + (s_sr_ff[0] ? dd_sh_ff : vs_sh_ff);
            dd_sh_in = {dd_sh_ff[22:0], 1'b0};
            vs_sh_in = {vs_sh_ff[22:0], 1'b0};
            s_sr_in = {1'b0, s_sr_ff[7:1]};
            cnt_in = cnt_ff + 3'd1;
            if (cnt_ff == sbrs_pkg::DIGIT_LAST) begin
               cnt_in = 3'd0;
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            cnt_in = cnt_ff + 3'd1;
            if (cnt_ff == DIV_STEP_OUT) begin
               mean_in[trk_ff] = mean_ff[trk_ff] + step8;
            end
            if (cnt_ff == DIV_VAR_OUT) begin
               var_in[trk_ff] = div_q;
               sq_cmd.start = 1'b1;
               if (job_ff == last_job) begin
                  state_in = ST_WAIT;
               end else begin
                  job_in = job_ff + 2'd1;
                  state_in = ST_LOAD;
               end
            end
         end
         ST_WAIT: begin
            if (!sq_stat.busy) begin
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               out_avg_in = mean_ff;
               out_dev_in = dev_ff;
               rsp_valid_in = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         job_ff <= JOB_BAND;
         cnt_ff <= 3'd0;
         for (int i = 0; i < sbrs_pkg::NUM_TRK; i++) begin
            smooth_ff[i] <= sbrs_pkg::SMOOTH_RESET;
            mean_ff[i] <= 8'd0;
            var_ff[i] <= 16'd0;
            dev_ff[i] <= 8'd0;
         end
         win_len_ff <= sbrs_pkg::WINDOW_RESET;
         win_low_ff <= 8'hFF;
         win_high_ff <= 8'h00;
         win_cnt_ff <= 7'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         job_ff <= job_in;
         cnt_ff <= cnt_in;
         smooth_ff <= smooth_in;
         mean_ff <= mean_in;
         var_ff <= var_in;
         dev_ff <= dev_in;
         win_len_ff <= win_len_in;
         win_low_ff <= win_low_in;
         win_high_ff <= win_high_in;
         win_cnt_ff <= win_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      level_ff <= level_in;
      band_trk_ff <= band_trk_in;
      low_pk_ff <= low_pk_in;
      high_pk_ff <= high_pk_in;
      fire_ff <= fire_in;
      trk_ff <= trk_in;
      neg_ff <= neg_in;
      mag_sr_ff <= mag_sr_in;
      s_sr_ff <= s_sr_in;
      md_ff <= md_in;
      sq_acc_ff <= sq_acc_in;
      prod_acc_ff <= prod_acc_in;
      dd_sh_ff <= dd_sh_in;
      vs_sh_ff <= vs_sh_in;
      num_acc_ff <= num_acc_in;
      out_avg_ff <= out_avg_in;
      out_dev_ff <= out_dev_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_overall_average = out_avg_ff[sbrs_pkg::TRK_OVERALL];
   assign rsp_overall_deviation = out_dev_ff[sbrs_pkg::TRK_OVERALL];
   assign rsp_bass_average = out_avg_ff[sbrs_pkg::TRK_BASS];
   assign rsp_bass_deviation = out_dev_ff[sbrs_pkg::TRK_BASS];
   assign rsp_mid_average = out_avg_ff[sbrs_pkg::TRK_MID];
   assign rsp_mid_deviation = out_dev_ff[sbrs_pkg::TRK_MID];
   assign rsp_treble_average = out_avg_ff[sbrs_pkg::TRK_TREBLE];
   assign rsp_treble_deviation = out_dev_ff[sbrs_pkg::TRK_TREBLE];
   assign rsp_low_peak_average = out_avg_ff[sbrs_pkg::TRK_LOW];
   assign rsp_low_peak_deviation = out_dev_ff[sbrs_pkg::TRK_LOW];
   assign rsp_high_peak_average = out_avg_ff[sbrs_pkg::TRK_HIGH];
   assign rsp_high_peak_deviation = out_dev_ff[sbrs_pkg::TRK_HIGH];

endmodule

// ===== sv/sbrs_div255.sv =====
// Two-stage floor divide by 255 for values below 2^24.
module sbrs_div255 (
   input  logic        clock,
   input  logic [23:0] in_x,
   output logic [15:0] out_q
);

   logic [24:0] sum;
   logic [16:0] approx_in, approx_ff;
   logic [23:0] x_in, x_ff;
   logic [24:0] back;
   logic [24:0] rem;
   logic [16:0] q_in, q_ff;

   // x/255 = x/256 * (1 + 1/256 + 1/65536 + ...); estimate is q or q-1
   always_comb begin
      sum = {1'b0, in_x} + {9'b0, in_x[23:8]} + {17'b0, in_x[23:16]};
      approx_in = sum[24:8];
      x_in = in_x;
   end

   always_comb begin
      back = {approx_ff, 8'b0} - {8'b0, approx_ff};
      rem = {1'b0, x_ff} - back;
      if (rem >= {17'b0, sbrs_pkg::DIVISOR}) begin
         q_in = approx_ff + 17'd1;
      end else begin
         q_in = approx_ff;
      end
   end

   always_ff @(posedge clock) begin
      approx_ff <= approx_in;
      x_ff <= x_in;
      q_ff <= q_in;
   end

   assign out_q = q_ff[15:0];

endmodule

// ===== sv/sbrs_sqrt.sv =====
// Floor square root of a 16-bit word, two radicand bits per cycle.
module sbrs_sqrt (
   input  logic                    clock,
   input  logic                    reset,
   input  sbrs_pkg::sq_cmd_type    cmd,
   output sbrs_pkg::sq_stat_type   stat
);

   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [2:0]  cnt_ff, cnt_in;
   logic [15:0] x_ff, x_in;
   logic [8:0]  rem_ff, rem_in;
   logic [7:0]  root_ff, root_in;
   logic [2:0]  trk_ff, trk_in;

   logic [10:0] cand;
   logic [10:0] trial;
   logic [10:0] diff;
   logic        fit;

   always_comb begin
      cand = {rem_ff, x_ff[15:14]};
      trial = {1'b0, root_ff, 2'b01};
      fit = (cand >= trial);
      diff = cand - trial;

      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in = cnt_ff;
      x_in = x_ff;
      rem_in = rem_ff;
      root_in = root_ff;
      trk_in = trk_ff;

      if (cmd.start) begin
         busy_in = 1'b1;
         cnt_in = 3'd0;
         x_in = cmd.value;
         rem_in = 9'd0;
         root_in = 8'd0;
         trk_in = cmd.trk;
      end else if (busy_ff) begin
         x_in = {x_ff[13:0], 2'b00};
         // remainder stays at most twice the partial root
         rem_in = fit ? diff[8:0] : cand[8:0];
         root_in = {root_ff[6:0], fit};
         cnt_in = cnt_ff + 3'd1;
         if (cnt_ff == sbrs_pkg::DIGIT_LAST) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff <= 3'd0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff <= x_in;
      rem_ff <= rem_in;
      root_ff <= root_in;
      trk_ff <= trk_in;
   end

   always_comb begin
      stat.busy = busy_ff | done_ff;
      stat.done = done_ff;
      stat.trk = trk_ff;
      stat.root = root_ff;
   end

endmodule
